// File: rtl/tsb_pkg.sv
// Shared types, constants and character helpers for the text screen buffer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package tsb_pkg;

  localparam int ROWS_DEF = 24;
  localparam int COLS_DEF = 40;

  localparam int OP_W   = 3;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 8;
  localparam int RROW_W = 5;
  localparam int RCOL_W = 6;
  localparam int ROW_FW = 5;
  localparam int COL_FW = 6;
  localparam int CFG_IW = 1;
  localparam int CFG_DW = 1;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
  localparam logic [CHAR_W-1:0] CH_QUEST = 8'h3F;
  localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

  typedef enum logic [OP_W-1:0] {
    OP_PUT, OP_BS, OP_MOVE_COL, OP_MOVE_ROW, OP_STYLE, OP_CLEAR, OP_PUNCT, OP_READ
  } opcode_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_LOWER, REG_CAP
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CELL_WAIT, ST_CELL_OP, ST_NL, ST_SCROLL,
    ST_NF1, ST_NF2, ST_NF3, ST_NF4, ST_CLR, ST_FINISH
  } ctl_state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_CELL, CMD_NL, CMD_SCROLL_STEP, CMD_NF_ROW1,
    CMD_NF_ROW2, CMD_NF_SAVE, CMD_NF_EVAL, CMD_CLR_STEP, CMD_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   in_ready;
  } dp_cmd_t;

  typedef struct packed {
    logic    in_valid;
    opcode_t in_op;
    logic    in_nl;
    opcode_t op;
    logic    wrap;
    logic    at_bottom;
    logic    nf_needed;
    logic    sweep_all_last;
    logic    sweep_row_last;
    logic    out_free;
  } dp_stat_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_upper(input logic [CHAR_W-1:0] c);
    return c >= 8'h41 && c <= 8'h5A;
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return is_upper(c) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_punct(input logic [CHAR_W-1:0] c);
    return (c == CH_DOT) || (c == CH_BANG) || (c == CH_QUEST);
  endfunction

endpackage

// File: rtl/tsb_if.sv
// Valid/ready channel interfaces for the command beat and the result beat.
// Depends on tsb_pkg for field widths.
`timescale 1ns / 1ps

interface tsb_in_if;
  import tsb_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [CHAR_W-1:0]        char_code;
  logic signed [POS_W-1:0]  position;
  logic                     flag_value;
  logic [RROW_W-1:0]        read_row;
  logic [RCOL_W-1:0]        read_col;

  modport source (output valid, opcode, char_code, position, flag_value, read_row,
                  read_col, input ready);
  modport sink (input valid, opcode, char_code, position, flag_value, read_row,
                read_col, output ready);
endinterface

interface tsb_out_if;
  import tsb_pkg::*;
  logic              valid;
  logic              ready;
  logic [ROW_FW-1:0] cursor_row;
  logic [COL_FW-1:0] cursor_col;
  logic [CHAR_W-1:0] cell_char;
  logic              cell_style;
  logic              sentence_end_flag;
  logic              scrolled;

  modport source (output valid, cursor_row, cursor_col, cell_char, cell_style,
                  sentence_end_flag, scrolled, input ready);
  modport sink (input valid, cursor_row, cursor_col, cell_char, cell_style,
                sentence_end_flag, scrolled, output ready);
endinterface

// File: rtl/text_screen_buffer.sv
// Top level of the text screen buffer: sequencer plus datapath.
// Depends on tsb_pkg, tsb_if, tsb_ctrl and tsb_dp.
//
//   port     dir   kind        beat
//   in_ch    in    valid/ready one command (opcode and operands)
//   out_ch   out   valid/ready one result per command
//   cfg_*    in    write only  lower_case_mode (0), auto_capitalize (1)
//
// Put char, backspace and read cell step through load, wait, cell and finish;
// moves, style and flag through load and finish. A newline adds its own step
// plus, when needed, a check of the two rows above for blanks; a wrap adds these
// to a put, a scroll a pass blanking a row (one cell a cycle). Clear sweeps all
// cells; after reset the same sweep blanks the cell memory with in_ch.ready low.
// A command is taken while the previous result waits; a stalled result holds
// the following command in its last step.
`timescale 1ns / 1ps

module text_screen_buffer #(
  parameter int ROWS    = tsb_pkg::ROWS_DEF,
  parameter int COLUMNS = tsb_pkg::COLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tsb_in_if.sink                     in_ch,
  tsb_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [tsb_pkg::CFG_IW-1:0] cfg_index,
  input  logic [tsb_pkg::CFG_DW-1:0] cfg_wdata
);
  import tsb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tsb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  tsb_dp #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: rtl/tsb_ctrl.sv
// Sequencer for the text screen buffer: walks each command through its steps.
// Depends on tsb_pkg; drives tsb_dp through dp_cmd_t and reads dp_stat_t.
`timescale 1ns / 1ps

module tsb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  tsb_pkg::dp_stat_t stat,
  output tsb_pkg::dp_cmd_t  cmd
);
  import tsb_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_INIT;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = CMD_NONE;
    cmd.in_ready = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.op = CMD_CLR_STEP;
        if (stat.sweep_all_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          cmd.op = CMD_LOAD;
          case (stat.in_op) inside
            OP_PUT:          state_nxt = stat.in_nl ? ST_NL : ST_CELL_WAIT;
            OP_BS, OP_READ:  state_nxt = ST_CELL_WAIT;
            OP_CLEAR:        state_nxt = ST_CLR;
            default:         state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_CELL_WAIT: state_nxt = ST_CELL_OP;
      ST_CELL_OP: begin
        cmd.op = CMD_CELL;
        state_nxt = (stat.op == OP_PUT && stat.wrap) ? ST_NL : ST_FINISH;
      end
      ST_NL: begin
        cmd.op = CMD_NL;
        state_nxt = stat.at_bottom ? ST_SCROLL : ST_NF1;
      end
      ST_SCROLL: begin
        cmd.op = CMD_SCROLL_STEP;
        if (stat.sweep_row_last) state_nxt = ST_NF1;
      end
      ST_NF1: begin
        if (stat.nf_needed) begin
          cmd.op = CMD_NF_ROW1;
          state_nxt = ST_NF2;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_NF2: begin
        cmd.op = CMD_NF_ROW2;
        state_nxt = ST_NF3;
      end
      ST_NF3: begin
        cmd.op = CMD_NF_SAVE;
        state_nxt = ST_NF4;
      end
      ST_NF4: begin
        cmd.op = CMD_NF_EVAL;
        state_nxt = ST_FINISH;
      end
      ST_CLR: begin
        cmd.op = CMD_CLR_STEP;
        if (stat.sweep_all_last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.op = CMD_FINISH;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/tsb_dp.sv
// Datapath for the text screen buffer: cursor, ring offset, cell and row-count
// memories, config bits and the result register. Depends on tsb_pkg, tsb_if.
`timescale 1ns / 1ps

module tsb_dp #(
  parameter int ROWS    = tsb_pkg::ROWS_DEF,
  parameter int COLUMNS = tsb_pkg::COLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tsb_in_if.sink                     in_ch,
  tsb_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [tsb_pkg::CFG_IW-1:0] cfg_index,
  input  logic [tsb_pkg::CFG_DW-1:0] cfg_wdata,
  input  tsb_pkg::dp_cmd_t           cmd,
  output tsb_pkg::dp_stat_t          stat
);
  import tsb_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int NW    = $clog2(COLUMNS + 1);

  // cell word: {style, char}
  logic [CHAR_W:0] cell_mem [CELLS];
  logic [NW-1:0]   cnt_mem  [ROWS];
  logic [CHAR_W:0] cell_q;
  logic [NW-1:0]   cnt_q;

  logic [RW-1:0]     cur_row_r, cur_row_nxt, top_r, top_nxt, phys_r, phys_nxt;
  logic [CW-1:0]     cur_col_r, cur_col_nxt, col_r, col_nxt;
  logic              style_r, style_nxt, punct_r, punct_nxt;
  logic              lcm_r, lcm_nxt, cap_r, cap_nxt;
  opcode_t           op_r, op_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt, rd_char_r, rd_char_nxt;
  logic              rd_style_r, rd_style_nxt, oor_r, oor_nxt;
  logic              scrolled_r, scrolled_nxt, zero1_r, zero1_nxt;
  logic [AW-1:0]     sweep_r, sweep_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ROW_FW-1:0] out_row_r, out_row_nxt;
  logic [COL_FW-1:0] out_col_r, out_col_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_style_r, out_style_nxt, out_punct_r, out_punct_nxt;
  logic              out_scr_r, out_scr_nxt;

  logic              cell_we, cnt_we;
  logic [AW-1:0]     cell_waddr, cell_raddr;
  logic [CHAR_W:0]   cell_wdata;
  logic [RW-1:0]     cnt_waddr;
  logic [NW-1:0]     cnt_wdata;
  opcode_t           in_op;
  logic              punct_fin;

  function automatic logic [RW-1:0] phys(input logic [RW-1:0] top, input logic [RW-1:0] v);
    logic [RW:0] s;
    s = {1'b0, top} + {1'b0, v};
    if (s >= (RW+1)'(ROWS)) s = s - (RW+1)'(ROWS);
    return s[RW-1:0];
  endfunction

  assign in_op      = opcode_t'(in_ch.opcode);
  assign cell_raddr = AW'(phys_r) * AW'(COLUMNS) + AW'(col_r);
  assign punct_fin  = punct_r | ((op_r == OP_PUT) && is_punct(ch_r));

  assign in_ch.ready = cmd.in_ready;

  assign stat.in_valid       = in_ch.valid;
  assign stat.in_op          = in_op;
  assign stat.in_nl          = (in_ch.char_code == CH_NL);
  assign stat.op             = op_r;
  assign stat.wrap           = (cur_col_r == CW'(COLUMNS - 1));
  assign stat.at_bottom      = (cur_row_r == RW'(ROWS - 1));
  assign stat.nf_needed      = (cur_row_r > RW'(2)) && !punct_r;
  assign stat.sweep_all_last = (sweep_r == AW'(CELLS - 1));
  assign stat.sweep_row_last = (sweep_r == AW'(COLUMNS - 1));
  assign stat.out_free       = !out_valid_r || out_ch.ready;

  always_comb begin
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    top_nxt       = top_r;
    phys_nxt      = phys_r;
    col_nxt       = col_r;
    style_nxt     = style_r;
    punct_nxt     = punct_r;
    lcm_nxt       = lcm_r;
    cap_nxt       = cap_r;
    op_nxt        = op_r;
    ch_nxt        = ch_r;
    rd_char_nxt   = rd_char_r;
    rd_style_nxt  = rd_style_r;
    oor_nxt       = oor_r;
    scrolled_nxt  = scrolled_r;
    zero1_nxt     = zero1_r;
    sweep_nxt     = sweep_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_char_nxt  = out_char_r;
    out_style_nxt = out_style_r;
    out_punct_nxt = out_punct_r;
    out_scr_nxt   = out_scr_r;
    cell_we       = 1'b0;
    cell_waddr    = cell_raddr;
    cell_wdata    = {1'b0, CH_SPACE};
    cnt_we        = 1'b0;
    cnt_waddr     = phys_r;
    cnt_wdata     = '0;

    case (cmd.op)
      CMD_LOAD: begin
        op_nxt       = in_op;
        ch_nxt       = in_ch.char_code;
        scrolled_nxt = 1'b0;
        rd_char_nxt  = '0;
        rd_style_nxt = 1'b0;
        oor_nxt      = 1'b0;
        sweep_nxt    = '0;
        col_nxt      = cur_col_r;
        phys_nxt     = phys(top_r, cur_row_r);
        unique case (in_op)
          OP_PUT: begin
            if (lcm_r) begin
              if (cap_r && punct_r && is_alnum(in_ch.char_code)) punct_nxt = 1'b0;
              else if (is_upper(in_ch.char_code)) ch_nxt = in_ch.char_code + CASE_OFS;
            end
          end
          OP_BS: begin
            if (cur_col_r != '0) begin
              cur_col_nxt = cur_col_r - 1'b1;
            end else if (cur_row_r != '0) begin
              cur_row_nxt = cur_row_r - 1'b1;
              cur_col_nxt = CW'(COLUMNS - 1);
            end
            col_nxt  = cur_col_nxt;
            phys_nxt = phys(top_r, cur_row_nxt);
          end
          OP_MOVE_COL: begin
            if (in_ch.position[POS_W-1]) cur_col_nxt = '0;
            else if (32'(in_ch.position[POS_W-2:0]) >= COLUMNS) cur_col_nxt = CW'(COLUMNS - 1);
            else cur_col_nxt = CW'(in_ch.position[POS_W-2:0]);
          end
          OP_MOVE_ROW: begin
            if (in_ch.position[POS_W-1]) cur_row_nxt = '0;
            else if (32'(in_ch.position[POS_W-2:0]) >= ROWS) cur_row_nxt = RW'(ROWS - 1);
            else cur_row_nxt = RW'(in_ch.position[POS_W-2:0]);
          end
          OP_STYLE: style_nxt = in_ch.flag_value;
          OP_PUNCT: punct_nxt = in_ch.flag_value;
          OP_READ: begin
            if (32'(in_ch.read_row) < ROWS && 32'(in_ch.read_col) < COLUMNS) begin
              phys_nxt = phys(top_r, RW'(in_ch.read_row));
              col_nxt  = CW'(in_ch.read_col);
            end else begin
              oor_nxt  = 1'b1;
              phys_nxt = '0;
              col_nxt  = '0;
            end
          end
          OP_CLEAR: ;
          default: ;
        endcase
      end
      CMD_CELL: begin
        if (op_r == OP_READ) begin
          if (!oor_r) begin
            rd_char_nxt  = cell_q[CHAR_W-1:0];
            rd_style_nxt = cell_q[CHAR_W];
          end
        end else begin
          cell_we   = 1'b1;
          cnt_we    = 1'b1;
          if (op_r == OP_PUT) begin
            cell_wdata  = {style_r, ch_r};
            // at the line end the newline step takes the cursor to column 0
            cur_col_nxt = stat.wrap ? '0 : cur_col_r + 1'b1;
            cnt_wdata   = cnt_q - NW'(!is_space(cell_q[CHAR_W-1:0])) + NW'(!is_space(ch_r));
          end else begin
            // backspace keeps the cell's style
            cell_wdata = {cell_q[CHAR_W], CH_SPACE};
            cnt_wdata  = cnt_q - NW'(!is_space(cell_q[CHAR_W-1:0]));
          end
        end
      end
      CMD_NL: begin
        cur_col_nxt = '0;
        sweep_nxt   = '0;
        if (cur_row_r != RW'(ROWS - 1)) cur_row_nxt = cur_row_r + 1'b1;
      end
      CMD_SCROLL_STEP: begin
        // blank the old top row, which becomes the new bottom row
        cell_we    = 1'b1;
        cell_waddr = AW'(top_r) * AW'(COLUMNS) + sweep_r;
        sweep_nxt  = sweep_r + 1'b1;
        if (sweep_r == '0) begin
          cnt_we    = 1'b1;
          cnt_waddr = top_r;
        end
        if (sweep_r == AW'(COLUMNS - 1)) begin
          top_nxt      = (top_r == RW'(ROWS - 1)) ? '0 : top_r + 1'b1;
          scrolled_nxt = 1'b1;
        end
      end
      CMD_NF_ROW1: phys_nxt  = phys(top_r, cur_row_r - RW'(1));
      CMD_NF_ROW2: phys_nxt  = phys(top_r, cur_row_r - RW'(2));
      CMD_NF_SAVE: zero1_nxt = (cnt_q == '0);
      CMD_NF_EVAL: punct_nxt = zero1_r && (cnt_q == '0);
      CMD_CLR_STEP: begin
        cell_we    = 1'b1;
        cell_waddr = sweep_r;
        sweep_nxt  = sweep_r + 1'b1;
        if (32'(sweep_r) < ROWS) begin
          cnt_we    = 1'b1;
          cnt_waddr = RW'(sweep_r);
        end
        if (sweep_r == AW'(CELLS - 1)) begin
          top_nxt     = '0;
          cur_row_nxt = '0;
          cur_col_nxt = '0;
        end
      end
      CMD_FINISH: begin
        punct_nxt     = punct_fin;
        out_valid_nxt = 1'b1;
        out_row_nxt   = ROW_FW'(cur_row_r);
        out_col_nxt   = COL_FW'(cur_col_r);
        out_char_nxt  = rd_char_r;
        out_style_nxt = rd_style_r;
        out_punct_nxt = punct_fin;
        out_scr_nxt   = scrolled_r;
      end
      default: ;
    endcase

    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LOWER: lcm_nxt = cfg_wdata[0];
        REG_CAP:   cap_nxt = cfg_wdata[0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      top_r       <= '0;
      style_r     <= 1'b0;
      punct_r     <= 1'b0;
      lcm_r       <= 1'b0;
      cap_r       <= 1'b1;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      top_r       <= top_nxt;
      style_r     <= style_nxt;
      punct_r     <= punct_nxt;
      lcm_r       <= lcm_nxt;
      cap_r       <= cap_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phys_r      <= phys_nxt;
    col_r       <= col_nxt;
    op_r        <= op_nxt;
    ch_r        <= ch_nxt;
    rd_char_r   <= rd_char_nxt;
    rd_style_r  <= rd_style_nxt;
    oor_r       <= oor_nxt;
    scrolled_r  <= scrolled_nxt;
    zero1_r     <= zero1_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_char_r  <= out_char_nxt;
    out_style_r <= out_style_nxt;
    out_punct_r <= out_punct_nxt;
    out_scr_r   <= out_scr_nxt;
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    cell_q <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_q <= cnt_mem[phys_r];
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.cursor_row        = out_row_r;
  assign out_ch.cursor_col        = out_col_r;
  assign out_ch.cell_char         = out_char_r;
  assign out_ch.cell_style        = out_style_r;
  assign out_ch.sentence_end_flag = out_punct_r;
  assign out_ch.scrolled          = out_scr_r;

`ifndef NO_ASSERTIONS
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_row_r) < ROWS) else $error("cursor row beyond screen");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_col_r) < COLUMNS) else $error("cursor column beyond screen");
  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(top_r) < ROWS) else $error("ring offset beyond screen");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_we |-> 32'(cnt_wdata) <= COLUMNS) else $error("row count overflow");
`endif

endmodule
